/* hw/rtl/forb_pkg.sv */
`default_nettype none

package forb_pkg;

    localparam int unsigned COORD_W   = 64;
    localparam int unsigned WIDE_W    = COORD_W + 1;
    localparam int unsigned RENDER_W  = 32;
    localparam int unsigned GRID_W    = 48;
    localparam int unsigned COOL_W    = 16;
    localparam int unsigned EPOCH_W   = 32;
    localparam int unsigned FRAMES_W  = 32;
    localparam int unsigned OP_W      = 3;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned AXES      = 3;

    localparam int unsigned DIV_STEPS = COORD_W;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [OP_W-1:0] OP_TICK        = 3'd0;
    localparam logic [OP_W-1:0] OP_SET_CAMERA  = 3'd1;
    localparam logic [OP_W-1:0] OP_FORCE_SHIFT = 3'd2;
    localparam logic [OP_W-1:0] OP_TO_RENDER   = 3'd3;
    localparam logic [OP_W-1:0] OP_TO_WORLD    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN        = 2'd2;

    localparam logic [GRID_W-1:0] GRID_RESET   = 48'd67108864;
    localparam logic [GRID_W-1:0] THRESH_RESET = 48'd33554432;
    localparam logic [COOL_W-1:0] COOL_RESET   = 16'd60;

    localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] RENDER_MIN_EXT =
        {{(COORD_W-RENDER_W+1){1'b1}}, {(RENDER_W-1){1'b0}}};
    localparam logic [COORD_W-1:0] RENDER_MAX_EXT =
        {{(COORD_W-RENDER_W+1){1'b0}}, {(RENDER_W-1){1'b1}}};

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [WIDE_W-1:0]  wide_t;

    typedef struct packed {
        logic busy;
        logic done;
    } forb_div_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/forb_in_if.sv */
`default_nettype none

interface forb_in_if import forb_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [OP_W-1:0]            operation;
    logic signed [COORD_W-1:0]  world_x;
    logic signed [COORD_W-1:0]  world_y;
    logic signed [COORD_W-1:0]  world_z;
    logic signed [RENDER_W-1:0] render_x;
    logic signed [RENDER_W-1:0] render_y;
    logic signed [RENDER_W-1:0] render_z;

    modport source (
        output valid, operation, world_x, world_y, world_z,
        output render_x, render_y, render_z,
        input  ready
    );

    modport sink (
        input  valid, operation, world_x, world_y, world_z,
        input  render_x, render_y, render_z,
        output ready
    );
endinterface

`default_nettype wire

/* hw/rtl/forb_out_if.sv */
`default_nettype none

interface forb_out_if import forb_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      shifted;
    logic [EPOCH_W-1:0]        epoch;
    logic signed [COORD_W-1:0] result_x;
    logic signed [COORD_W-1:0] result_y;
    logic signed [COORD_W-1:0] result_z;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic                      saturated;

    modport source (
        output valid, shifted, epoch, result_x, result_y, result_z,
        output origin_x, origin_y, origin_z, saturated,
        input  ready
    );

    modport sink (
        input  valid, shifted, epoch, result_x, result_y, result_z,
        input  origin_x, origin_y, origin_z, saturated,
        output ready
    );
endinterface

`default_nettype wire

/* hw/rtl/floating_origin_rebase.sv */
// every operation but a tick that needs a snap runs through the add, evaluate and finish states
// a tick that needs a snap also runs the 64-step bit-serial remainder units
// (one per axis, run side by side), plus load, adjust and compare steps
// one request in flight; a new one is taken once the last has finished, also while a result waits
// reset: asynchronous, active low; origin, camera, epoch and frame count clear to zero,
// registers return to grid 1024 m, threshold 512 m, cooldown 60
`default_nettype none

module floating_origin_rebase import forb_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    forb_in_if.sink                   cmd,
    forb_out_if.source                rsp,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [GRID_W-1:0]    cfg_wdata
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ADD  = 3'd1;
    localparam logic [2:0] ST_EVAL = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_SNAP = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0]                state_reg;
    logic [GRID_W-1:0]         grid_reg;
    logic [GRID_W-1:0]         thresh_reg;
    logic [COOL_W-1:0]         cool_reg;
    coord_t [AXES-1:0]         origin_reg;
    coord_t [AXES-1:0]         camera_reg;
    logic [EPOCH_W-1:0]        shift_count_reg;
    logic [FRAMES_W-1:0]       frames_reg;
    logic                      rsp_valid_reg;

    logic [OP_W-1:0]           op_reg;
    coord_t [AXES-1:0]         world_reg;
    logic [AXES-1:0][RENDER_W-1:0] render_reg;
    wide_t [AXES-1:0]          sum_reg;
    coord_t [AXES-1:0]         res_reg;
    logic                      sat_reg;
    logic                      shifted_reg;

    logic                      out_shifted_reg;
    logic [EPOCH_W-1:0]        out_epoch_reg;
    coord_t [AXES-1:0]         out_res_reg;
    coord_t [AXES-1:0]         out_origin_reg;
    logic                      out_sat_reg;

    wide_t [AXES-1:0]          sum_next;
    coord_t [AXES-1:0]         conv_res;
    logic [AXES-1:0]           conv_sat;
    logic [AXES-1:0]           need;
    coord_t [AXES-1:0]         snap;
    logic [AXES-1:0]           differs;
    logic [AXES-1:0][GRID_W-1:0] floor_rem;
    forb_div_stat_t [AXES-1:0] div_stat;
    logic [GRID_W-1:0]         grid_eff;
    logic                      cool_ok;
    logic                      accept;
    logic                      div_start;
    logic                      force_shift;
    logic                      snap_shift;
    logic                      fin_fire;

    assign accept      = (state_reg == ST_IDLE) && cmd.valid;
    assign cool_ok     = frames_reg >= FRAMES_W'(cool_reg);
    assign div_start   = (state_reg == ST_EVAL) && (op_reg == OP_TICK) && cool_ok && (|need);
    assign force_shift = (state_reg == ST_EVAL) && (op_reg == OP_FORCE_SHIFT);
    assign snap_shift  = (state_reg == ST_SNAP) && (|differs);
    assign fin_fire    = (state_reg == ST_FIN) && (!rsp_valid_reg || rsp.ready);
    assign grid_eff    = (grid_reg == '0) ? GRID_W'(1) : grid_reg;

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            case (op_reg)
                OP_TO_WORLD:
                    sum_next[i] = {origin_reg[i][COORD_W-1], origin_reg[i]}
                        + {{(WIDE_W-RENDER_W){render_reg[i][RENDER_W-1]}}, render_reg[i]};
                OP_TO_RENDER:
                    sum_next[i] = {world_reg[i][COORD_W-1], world_reg[i]}
                        - {origin_reg[i][COORD_W-1], origin_reg[i]};
                default:
                    sum_next[i] = {camera_reg[i][COORD_W-1], camera_reg[i]}
                        - {origin_reg[i][COORD_W-1], origin_reg[i]};
            endcase
        end
    end

    // offset test, clamps and snap, per axis
    always_comb
    begin
        logic [WIDE_W:0] d_ext;
        logic [WIDE_W:0] th_ext;
        logic [WIDE_W:0] above;
        logic [WIDE_W:0] below;
        logic [WIDE_W-1:0] snap_wide;
        logic top_ones;
        logic top_zeros;
        for (int i = 0; i < AXES; i++)
        begin
            d_ext  = {sum_reg[i][WIDE_W-1], sum_reg[i]};
            th_ext = {{(WIDE_W+1-GRID_W){1'b0}}, thresh_reg};
            above  = th_ext - d_ext;
            below  = d_ext + th_ext;
            need[i] = above[WIDE_W] | below[WIDE_W];

            top_ones  = &sum_reg[i][WIDE_W-1:RENDER_W-1];
            top_zeros = ~|sum_reg[i][WIDE_W-1:RENDER_W-1];
            conv_res[i] = '0;
            conv_sat[i] = 1'b0;
            if (op_reg == OP_TO_RENDER)
            begin
                if (top_ones || top_zeros)
                begin
                    conv_res[i] = sum_reg[i][COORD_W-1:0];
                end
                else
                begin
                    conv_res[i] = sum_reg[i][WIDE_W-1] ? RENDER_MIN_EXT : RENDER_MAX_EXT;
                    conv_sat[i] = 1'b1;
                end
            end
            else if (sum_reg[i][WIDE_W-1] != sum_reg[i][COORD_W-1])
            begin
                conv_res[i] = sum_reg[i][WIDE_W-1] ? COORD_MIN : COORD_MAX;
                conv_sat[i] = 1'b1;
            end
            else
            begin
                conv_res[i] = sum_reg[i][COORD_W-1:0];
            end

            // floored multiple below range clamps to the most negative value
            snap_wide = {camera_reg[i][COORD_W-1], camera_reg[i]}
                - {{(WIDE_W-GRID_W){1'b0}}, floor_rem[i]};
            snap[i] = (snap_wide[WIDE_W-1] != snap_wide[COORD_W-1]) ? COORD_MIN
                : snap_wide[COORD_W-1:0];
            differs[i] = snap[i] != origin_reg[i];
        end
    end

    for (genvar g = 0; g < AXES; g++)
    begin : g_rem
        forb_rem_serial u_rem (
            .clk       (clk),
            .rst_n     (rst_n),
            .start     (div_start),
            .value     (camera_reg[g]),
            .divisor   (grid_eff),
            .stat      (div_stat[g]),
            .floor_rem (floor_rem[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            grid_reg        <= GRID_RESET;
            thresh_reg      <= THRESH_RESET;
            cool_reg        <= COOL_RESET;
            origin_reg      <= '0;
            camera_reg      <= '0;
            shift_count_reg <= '0;
            frames_reg      <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_GRID_SIZE:       grid_reg   <= cfg_wdata;
                    CFG_SHIFT_THRESHOLD: thresh_reg <= cfg_wdata;
                    CFG_COOLDOWN:        cool_reg   <= cfg_wdata[COOL_W-1:0];
                    default:             ;
                endcase
            end

            if (fin_fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            if (accept && (cmd.operation == OP_TICK) && (frames_reg != '1))
            begin
                frames_reg <= frames_reg + 1'b1;
            end

            if ((state_reg == ST_EVAL) && (op_reg == OP_SET_CAMERA))
            begin
                camera_reg <= world_reg;
            end

            if (force_shift)
            begin
                origin_reg      <= world_reg;
                shift_count_reg <= shift_count_reg + 1'b1;
                frames_reg      <= '0;
            end
            else if (snap_shift)
            begin
                origin_reg      <= snap;
                shift_count_reg <= shift_count_reg + 1'b1;
                frames_reg      <= '0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd.valid)
                    begin
                        state_reg <= ST_ADD;
                    end
                end
                ST_ADD:
                begin
                    state_reg <= ST_EVAL;
                end
                ST_EVAL:
                begin
                    state_reg <= div_start ? ST_DIV : ST_FIN;
                end
                ST_DIV:
                begin
                    if (div_stat[0].done)
                    begin
                        state_reg <= ST_SNAP;
                    end
                end
                ST_SNAP:
                begin
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (fin_fire)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg        <= cmd.operation;
            world_reg[0]  <= cmd.world_x;
            world_reg[1]  <= cmd.world_y;
            world_reg[2]  <= cmd.world_z;
            render_reg[0] <= cmd.render_x;
            render_reg[1] <= cmd.render_y;
            render_reg[2] <= cmd.render_z;
            res_reg       <= '0;
            sat_reg       <= 1'b0;
            shifted_reg   <= 1'b0;
        end
        if (state_reg == ST_ADD)
        begin
            sum_reg <= sum_next;
        end
        if ((state_reg == ST_EVAL) && ((op_reg == OP_TO_RENDER) || (op_reg == OP_TO_WORLD)))
        begin
            res_reg <= conv_res;
            sat_reg <= |conv_sat;
        end
        if (force_shift || snap_shift)
        begin
            shifted_reg <= 1'b1;
        end
        if (fin_fire)
        begin
            out_shifted_reg <= shifted_reg;
            out_epoch_reg   <= shift_count_reg;
            out_res_reg     <= res_reg;
            out_origin_reg  <= origin_reg;
            out_sat_reg     <= sat_reg;
        end
    end

    assign cmd.ready     = (state_reg == ST_IDLE);
    assign rsp.valid     = rsp_valid_reg;
    assign rsp.shifted   = out_shifted_reg;
    assign rsp.epoch     = out_epoch_reg;
    assign rsp.result_x  = out_res_reg[0];
    assign rsp.result_y  = out_res_reg[1];
    assign rsp.result_z  = out_res_reg[2];
    assign rsp.origin_x  = out_origin_reg[0];
    assign rsp.origin_y  = out_origin_reg[1];
    assign rsp.origin_z  = out_origin_reg[2];
    assign rsp.saturated = out_sat_reg;

`ifndef SYNTH
    a_rem_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (div_stat[0] == div_stat[1]) && (div_stat[1] == div_stat[2]))
        else $error("remainder units out of step");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat[0].done |-> (state_reg == ST_DIV))
        else $error("remainder done outside the divide step");

    a_shift_clears_frames: assert property (@(posedge clk) disable iff (!rst_n)
        (shift_count_reg != $past(shift_count_reg)) |-> (frames_reg == '0))
        else $error("epoch moved without clearing the frame count");

    a_request_starts_add: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> (state_reg == ST_ADD))
        else $error("accepted request did not start work");
`endif

endmodule

`default_nettype wire

/* hw/rtl/forb_rem_serial.sv */
`default_nettype none

module forb_rem_serial import forb_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [COORD_W-1:0] value,
    input  wire logic [GRID_W-1:0] divisor,
    output forb_div_stat_t         stat,
    output logic [GRID_W-1:0]      floor_rem
);

    logic                 run_reg;
    logic                 adj_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [COORD_W-1:0]   num_reg;
    logic [GRID_W-1:0]    rem_reg;
    logic                 neg_reg;
    logic [GRID_W-1:0]    floor_rem_reg;

    logic [GRID_W:0]      trial;
    logic [GRID_W+1:0]    trial_diff;
    logic [GRID_W-1:0]    rem_next;

    // one quotient bit a cycle, only the remainder is kept
    always_comb
    begin
        trial      = {rem_reg, num_reg[COORD_W-1]};
        trial_diff = {1'b0, trial} - {2'b00, divisor};
        rem_next   = trial_diff[GRID_W+1] ? trial[GRID_W-1:0] : trial_diff[GRID_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            adj_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= adj_reg;
            adj_reg  <= run_reg && !start && (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // divide the magnitude, negative values are floored afterwards
            num_reg <= value[COORD_W-1] ? (COORD_W'(0) - value) : value;
            neg_reg <= value[COORD_W-1];
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            num_reg <= {num_reg[COORD_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
        if (adj_reg)
        begin
            floor_rem_reg <= (neg_reg && (rem_reg != '0)) ? (divisor - rem_reg) : rem_reg;
        end
    end

    assign stat.busy = run_reg | adj_reg;
    assign stat.done = done_reg;
    assign floor_rem = floor_rem_reg;

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
    import forb_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED_LO = OP_TO_WORLD + 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [2:0][COORD_W-1:0]  world;
        logic [2:0][RENDER_W-1:0] render;
        logic                     fence;
    } rebase_req_t;

    typedef struct packed {
        logic                    shifted;
        logic [EPOCH_W-1:0]      epoch;
        logic [2:0][COORD_W-1:0] res;
        logic [2:0][COORD_W-1:0] org;
        logic                    sat;
    } rebase_rsp_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [GRID_W-1:0]    cfg_wdata;

    forb_in_if  cmd_if ();
    forb_out_if rsp_if ();

    floating_origin_rebase u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_if),
        .rsp       (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state
    logic [2:0][COORD_W-1:0] world_origin;
    logic [2:0][COORD_W-1:0] cam_pos;
    logic [EPOCH_W-1:0]      epoch_count;
    logic [FRAMES_W-1:0]     frames_idle;
    logic [GRID_W-1:0]       grid_cfg;
    logic [GRID_W-1:0]       thresh_cfg;
    logic [COOL_W-1:0]       cool_cfg;

    rebase_req_t pending_q[$];
    rebase_rsp_t expect_q[$];
    rebase_req_t cur_req;

    int send_gap;
    int send_quiet;
    int take_gap;
    int take_quiet;
    int mismatch_count;
    int rsp_seen;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #8_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        if (mismatch_count < 200)
            $display("%0t mismatch on result %0d: %s", $time, rsp_seen, what);
        mismatch_count++;
    endtask

    function automatic logic [COORD_W-1:0] abs_gap(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
        return ($signed(a) >= $signed(b)) ? a - b : b - a;
    endfunction

    // floor towards minus infinity, clamped at the bottom of the range
    function automatic logic [COORD_W-1:0] floor_to_grid(logic [COORD_W-1:0] c,
                                                        logic [COORD_W-1:0] g);
        logic [COORD_W-1:0] mag;
        logic [COORD_W-1:0] rem;
        if (!c[COORD_W-1])
            return (c / g) * g;
        mag = -c;
        rem = mag % g;
        if (rem != '0)
            mag = mag + (g - rem);
        if (mag > COORD_MIN)
            mag = COORD_MIN;
        return -mag;
    endfunction

    function automatic void move_origin(logic [2:0][COORD_W-1:0] to);
        world_origin = to;
        epoch_count  = epoch_count + 1'b1;
        frames_idle  = '0;
    endfunction

    function automatic rebase_rsp_t predict_rebase(rebase_req_t rq);
        rebase_rsp_t             r;
        logic [2:0][COORD_W-1:0] snap;
        logic                    need;
        logic                    differs;
        logic [COORD_W-1:0]      g;
        logic [COORD_W-1:0]      d;
        logic [COORD_W-1:0]      ext;
        logic [COORD_W-1:0]      s;
        int                      i;
        r = '0;
        case (rq.op)
            OP_TICK:
            begin
                if (frames_idle != '1)
                    frames_idle = frames_idle + 1'b1;
                if (frames_idle >= {16'b0, cool_cfg})
                begin
                    need    = 1'b0;
                    differs = 1'b0;
                    g = (grid_cfg == '0) ? 64'd1 : {16'b0, grid_cfg};
                    for (i = 0; i < 3; i++)
                        if (abs_gap(cam_pos[i], world_origin[i]) > {16'b0, thresh_cfg})
                            need = 1'b1;
                    if (need)
                    begin
                        for (i = 0; i < 3; i++)
                        begin
                            snap[i] = floor_to_grid(cam_pos[i], g);
                            if (snap[i] != world_origin[i])
                                differs = 1'b1;
                        end
                        if (differs)
                        begin
                            move_origin(snap);
                            r.shifted = 1'b1;
                        end
                    end
                end
            end
            OP_SET_CAMERA:
                cam_pos = rq.world;
            OP_FORCE_SHIFT:
            begin
                move_origin(rq.world);
                r.shifted = 1'b1;
            end
            OP_TO_RENDER:
                for (i = 0; i < 3; i++)
                begin
                    if ($signed(rq.world[i]) >= $signed(world_origin[i]))
                    begin
                        d = rq.world[i] - world_origin[i];
                        if (d > RENDER_MAX_EXT)
                        begin
                            d = RENDER_MAX_EXT;
                            r.sat = 1'b1;
                        end
                        r.res[i] = d;
                    end
                    else
                    begin
                        d = world_origin[i] - rq.world[i];
                        if (d > -RENDER_MIN_EXT)
                        begin
                            d = -RENDER_MIN_EXT;
                            r.sat = 1'b1;
                        end
                        r.res[i] = -d;
                    end
                end
            OP_TO_WORLD:
                for (i = 0; i < 3; i++)
                begin
                    ext = {{(COORD_W-RENDER_W){rq.render[i][RENDER_W-1]}}, rq.render[i]};
                    s = world_origin[i] + ext;
                    if (world_origin[i][COORD_W-1] == ext[COORD_W-1] &&
                        s[COORD_W-1] != world_origin[i][COORD_W-1])
                    begin
                        s = world_origin[i][COORD_W-1] ? COORD_MIN : COORD_MAX;
                        r.sat = 1'b1;
                    end
                    r.res[i] = s;
                end
            default: ;
        endcase
        r.epoch = epoch_count;
        r.org   = world_origin;
        return r;
    endfunction

    // mostly short gaps, now and then a long one or a quiet stretch with none
    function automatic int pick_gap(inout int quiet);
        int unsigned roll;
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3)
        begin
            quiet = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 60)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_if.valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (cmd_if.valid && cmd_if.ready)
            begin
                expect_q.push_back(predict_rebase(cur_req));
                send_gap = pick_gap(send_quiet);
            end
            if (!cmd_if.valid || cmd_if.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    cmd_if.valid <= 1'b0;
                end
                else if (pending_q.size() != 0 &&
                         !(pending_q[0].fence && expect_q.size() != 0))
                begin
                    cur_req = pending_q.pop_front();
                    cmd_if.operation <= cur_req.op;
                    cmd_if.world_x   <= cur_req.world[0];
                    cmd_if.world_y   <= cur_req.world[1];
                    cmd_if.world_z   <= cur_req.world[2];
                    cmd_if.render_x  <= cur_req.render[0];
                    cmd_if.render_y  <= cur_req.render[1];
                    cmd_if.render_z  <= cur_req.render[2];
                    cmd_if.valid     <= 1'b1;
                end
                else
                    cmd_if.valid <= 1'b0;
            end
        end
    end

    task automatic check_result();
        rebase_rsp_t got;
        rebase_rsp_t want;
        int          i;
        got.shifted = rsp_if.shifted;
        got.epoch   = rsp_if.epoch;
        got.res[0]  = rsp_if.result_x;
        got.res[1]  = rsp_if.result_y;
        got.res[2]  = rsp_if.result_z;
        got.org[0]  = rsp_if.origin_x;
        got.org[1]  = rsp_if.origin_y;
        got.org[2]  = rsp_if.origin_z;
        got.sat     = rsp_if.saturated;
        if (expect_q.size() == 0)
        begin
            flag_mismatch("result with no request outstanding");
            return;
        end
        want = expect_q.pop_front();
        if (got.shifted !== want.shifted)
            flag_mismatch($sformatf("shifted %b, want %b", got.shifted, want.shifted));
        if (got.epoch !== want.epoch)
            flag_mismatch($sformatf("epoch %0d, want %0d", got.epoch, want.epoch));
        for (i = 0; i < 3; i++)
        begin
            if (got.res[i] !== want.res[i])
                flag_mismatch($sformatf("result axis %0d %h, want %h",
                                        i, got.res[i], want.res[i]));
            if (got.org[i] !== want.org[i])
                flag_mismatch($sformatf("origin axis %0d %h, want %h",
                                        i, got.org[i], want.org[i]));
        end
        if (got.sat !== want.sat)
            flag_mismatch($sformatf("saturated %b, want %b", got.sat, want.sat));
    endtask

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            take_gap = 0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                check_result();
                rsp_seen++;
            end
            if (take_gap > 0)
            begin
                take_gap--;
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    take_gap = pick_gap(take_quiet);
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GRID_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_GRID_SIZE:       grid_cfg   = val;
            CFG_SHIFT_THRESHOLD: thresh_cfg = val;
            CFG_COOLDOWN:        cool_cfg   = val[COOL_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle(input int limit);
        int n;
        n = 0;
        while ((pending_q.size() != 0 || cmd_if.valid || expect_q.size() != 0) && n < limit)
        begin
            @(negedge clk);
            n++;
        end
    endtask

    task automatic set_regs(input logic [GRID_W-1:0] grid, input logic [GRID_W-1:0] thresh,
                            input logic [GRID_W-1:0] cool_word);
        wait_idle(2_000_000);
        // a snapping tick may still be busy on the divider
        repeat (80) @(posedge clk);
        write_reg(CFG_GRID_SIZE, grid);
        write_reg(CFG_SHIFT_THRESHOLD, thresh);
        write_reg(CFG_COOLDOWN, cool_word);
    endtask

    task automatic push_req(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] a,
                            input logic [COORD_W-1:0] b, input logic [COORD_W-1:0] c);
        rebase_req_t rq;
        rq.op        = op;
        rq.world[0]  = a;
        rq.world[1]  = b;
        rq.world[2]  = c;
        rq.render[0] = a[RENDER_W-1:0];
        rq.render[1] = b[RENDER_W-1:0];
        rq.render[2] = c[RENDER_W-1:0];
        rq.fence     = 1'b0;
        pending_q.push_back(rq);
    endtask

    function automatic logic [COORD_W-1:0] rand_coord(logic [COORD_W-1:0] centre,
                                                      logic [COORD_W-1:0] span);
        logic [COORD_W-1:0] r;
        int unsigned        pick;
        pick = $urandom_range(0, 19);
        r = {$urandom, $urandom};
        if (pick == 0)
            return r;
        if (pick == 1)
            return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
        return centre + (r % (2 * span + 1)) - span;
    endfunction

    task automatic add_random(input int count, input logic [COORD_W-1:0] centre);
        rebase_req_t        rq;
        logic [COORD_W-1:0] span;
        int unsigned        roll;
        int                 k;
        int                 i;
        span = {16'b0, thresh_cfg} * 3 + {16'b0, grid_cfg} + 64'd16;
        for (k = 0; k < count; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 35)
                rq.op = OP_TICK;
            else if (roll < 55)
                rq.op = OP_SET_CAMERA;
            else if (roll < 62)
                rq.op = OP_FORCE_SHIFT;
            else if (roll < 78)
                rq.op = OP_TO_RENDER;
            else if (roll < 94)
                rq.op = OP_TO_WORLD;
            else
                rq.op = OP_UNUSED_LO + OP_W'($urandom_range(0, 2));
            for (i = 0; i < 3; i++)
            begin
                if (rq.op == OP_TO_RENDER)
                    rq.world[i] = rand_coord(centre, 64'h1_0000_0000);
                else
                    rq.world[i] = rand_coord(centre, span);
                case ($urandom_range(0, 9))
                    0:       rq.render[i] = RENDER_MAX_EXT[RENDER_W-1:0];
                    1:       rq.render[i] = RENDER_MIN_EXT[RENDER_W-1:0];
                    default: rq.render[i] = $urandom;
                endcase
            end
            // hold the sender back until everything in flight has answered
            rq.fence = (k == count / 2) || ($urandom_range(0, 99) == 0);
            pending_q.push_back(rq);
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_wdata        = '0;
        cmd_if.valid     = 1'b0;
        cmd_if.operation = OP_TICK;
        cmd_if.world_x   = '0;
        cmd_if.world_y   = '0;
        cmd_if.world_z   = '0;
        cmd_if.render_x  = '0;
        cmd_if.render_y  = '0;
        cmd_if.render_z  = '0;
        rsp_if.ready     = 1'b0;
        mismatch_count   = 0;
        rsp_seen         = 0;
        send_quiet       = 0;
        take_quiet       = 0;
        world_origin     = '0;
        cam_pos          = '0;
        epoch_count      = '0;
        frames_idle      = '0;
        grid_cfg         = GRID_RESET;
        thresh_cfg       = THRESH_RESET;
        cool_cfg         = COOL_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: unused codes, conversion limits, forced shifts
        push_req(OP_TICK, '0, '0, '0);
        push_req(OP_UNUSED_LO, COORD_MAX, COORD_MIN, {$urandom, $urandom});
        push_req(OP_UNUSED_LO + 3'd1, {$urandom, $urandom}, '1, '0);
        push_req(OP_UNUSED_LO + 3'd2, '1, '1, '1);
        push_req(OP_TO_RENDER, COORD_MAX, COORD_MIN, '0);
        push_req(OP_TO_RENDER, 64'h7FFF_FFFF, -64'h8000_0000, 64'h8000_0000);
        push_req(OP_TO_WORLD, 64'h7FFF_FFFF, 64'h8000_0000, '0);
        push_req(OP_FORCE_SHIFT, COORD_MAX, COORD_MIN, 64'h0123_4567_89AB_CDEF);
        push_req(OP_TO_WORLD, 64'h7FFF_FFFF, 64'h8000_0000, 64'h1);
        push_req(OP_TO_RENDER, '0, '0, 64'h0123_4567_89AB_CDEF);
        push_req(OP_FORCE_SHIFT, COORD_MAX, COORD_MIN, 64'h0123_4567_89AB_CDEF);
        push_req(OP_FORCE_SHIFT, '0, '0, '0);
        push_req(OP_SET_CAMERA, COORD_MAX, '0, '0);
        push_req(OP_TICK, '0, '0, '0);
        add_random(100, '0);

        // zero grid acts as one unit; offset taken exactly across the whole range
        set_regs('0, '0, '0);
        push_req(OP_TICK, '0, '0, '0);
        push_req(OP_TICK, '0, '0, '0);
        push_req(OP_FORCE_SHIFT, COORD_MIN, '0, '0);
        push_req(OP_TICK, '0, '0, '0);
        push_req(OP_SET_CAMERA, COORD_MAX, -64'd5, 64'd7);
        push_req(OP_TICK, '0, '0, '0);
        add_random(80, {$urandom, $urandom});

        // snapping below the range clamps; a snap onto the origin is no shift
        set_regs(48'd3, 48'd1, '0);
        push_req(OP_SET_CAMERA, COORD_MIN, '0, '0);
        push_req(OP_FORCE_SHIFT, '0, '0, '0);
        push_req(OP_TICK, '0, '0, '0);
        push_req(OP_SET_CAMERA, COORD_MIN + 64'd2, '0, '0);
        push_req(OP_TICK, '0, '0, '0);
        push_req(OP_SET_CAMERA, COORD_MIN + 64'd4, '0, '0);
        push_req(OP_TICK, '0, '0, '0);
        add_random(80, COORD_MIN + 64'd1000);

        set_regs(48'h8000_0000_0000, 48'h8000_0000_0000, '0);
        add_random(80, COORD_MAX - 64'h0010_0000_0000_0000);

        // junk above the cooldown field must be dropped
        set_regs(48'($urandom_range(1, 32'hFFFF_FFFF)) << $urandom_range(0, 12),
                 48'($urandom), 48'hA5A5_0000_FFFF);
        add_random(80, {$urandom, $urandom});

        set_regs(48'($urandom_range(1, 32'h00FF_FFFF)) << 16,
                 48'($urandom_range(0, 32'h00FF_FFFF)) << 14,
                 48'($urandom_range(0, 3)));
        add_random(80, '0);

        wait_idle(50_000);
        repeat (100) @(posedge clk);
        if (pending_q.size() != 0 || expect_q.size() != 0)
            flag_mismatch($sformatf("%0d requests unsent, %0d results missing",
                                    pending_q.size(), expect_q.size()));
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/forb_pkg.sv
hw/rtl/forb_in_if.sv
hw/rtl/forb_out_if.sv
hw/rtl/forb_rem_serial.sv
hw/rtl/floating_origin_rebase.sv
tb/tb.sv
